// ===== design/here_string_delimiter_scanner_macros.svh =====
// Assertion macros for the here-string delimiter scanner.
// Expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef HERE_STRING_DELIMITER_SCANNER_MACROS_SVH
`define HERE_STRING_DELIMITER_SCANNER_MACROS_SVH

// Same-cycle implication.
`define HSDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsds assertion failed");

// Next-cycle implication.
`define HSDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsds assertion failed");

`endif

// ===== design/hsds_pkg.sv =====
// Shared types, constants and helpers for the here-string delimiter scanner.
// No dependencies.
`default_nettype none

package hsds_pkg;

    localparam int CHAR_W       = 21;
    localparam int COUNT_W      = 16;
    localparam int STATUS_W     = 3;
    localparam int MAX_TERM_DEF = 32;
    localparam int PREFIX_LEN   = 7;
    localparam int POS_W        = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_NEEDWS,
        PH_GAP,
        PH_TERM,
        PH_BODY
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE,
        ST_PENDING,
        ST_DONE,
        ST_MISMATCH,
        ST_EARLY,
        ST_LONG
    } t_status;

    // controls from the sequencer to the terminator/window unit
    typedef struct packed {
        logic term_clr;   // drop the stored terminator
        logic term_push;  // shift current char into the terminator
        logic win_start;  // restart window fill with current char
        logic win_push;   // shift current char into the window
    } t_match_ctl;

    typedef struct packed {
        logic term_full;  // terminator already at its maximum length
        logic hit;        // window incl. current char equals terminator
    } t_match_sts;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        is_space = c inside {21'd32, 21'd9, 21'd13, 21'd10};
    endfunction

    // characters of "#string"
    function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0:    prefix_char = 21'd35;   // #
            3'd1:    prefix_char = 21'd115;  // s
            3'd2:    prefix_char = 21'd116;  // t
            3'd3:    prefix_char = 21'd114;  // r
            3'd4:    prefix_char = 21'd105;  // i
            3'd5:    prefix_char = 21'd110;  // n
            3'd6:    prefix_char = 21'd103;  // g
            default: prefix_char = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/hsds_if.sv =====
// Valid/ready channel interfaces for scanner input words and result words.
// Depends on hsds_pkg.
`default_nettype none

interface hsds_in_if import hsds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;

    modport source (output valid, start_req, char_code, end_of_input, input ready);
    modport sink   (input valid, start_req, char_code, end_of_input, output ready);
endinterface

interface hsds_out_if import hsds_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  consumed_count;

    modport source (output valid, status, consumed_count, input ready);
    modport sink   (input valid, status, consumed_count, output ready);
endinterface

`default_nettype wire

// ===== design/hsds_match.sv =====
// Terminator store and recent-character window with a parallel lane compare.
// Depends on hsds_pkg.
`default_nettype none

module hsds_match import hsds_pkg::*; #(
    parameter int MAX_TERM = MAX_TERM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire t_match_ctl        i_ctl,
    output t_match_sts             o_sts
);

    localparam int LEN_W = $clog2(MAX_TERM + 1);

    // both stores shift newest-first, so lane j pairs directly
    logic [CHAR_W-1:0] r_term [MAX_TERM];
    logic [CHAR_W-1:0] r_win  [MAX_TERM];
    logic [CHAR_W-1:0] win_next [MAX_TERM];
    logic [CHAR_W-1:0] term_next [MAX_TERM];
    logic [LEN_W-1:0]  r_term_len, n_term_len;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [MAX_TERM-1:0] lane_ok;
    logic              fill_ok;

    always_comb begin
        win_next[0]  = i_char;
        term_next[0] = i_char;
        for (int j = 1; j < MAX_TERM; j++) begin
            win_next[j]  = r_win[j-1];
            term_next[j] = r_term[j-1];
        end
        for (int j = 0; j < MAX_TERM; j++) begin
            lane_ok[j] = (LEN_W'(j) >= r_term_len) || (win_next[j] == r_term[j]);
        end
    end

    assign fill_ok = ({1'b0, r_fill} + (LEN_W+1)'(1)) >= {1'b0, r_term_len};

    assign o_sts.hit       = (&lane_ok) && fill_ok && (r_term_len != '0);
    assign o_sts.term_full = (r_term_len == LEN_W'(MAX_TERM));

    always_comb begin
        n_term_len = i_ctl.term_clr ? '0 : r_term_len;
        if (i_ctl.term_push) begin
            n_term_len = n_term_len + LEN_W'(1);
        end
        n_fill = r_fill;
        if (i_ctl.win_start) begin
            n_fill = LEN_W'(1);
        end else if (i_ctl.win_push && r_fill != LEN_W'(MAX_TERM)) begin
            n_fill = r_fill + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len <= '0;
            r_fill     <= '0;
        end else begin
            r_term_len <= n_term_len;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.term_push) begin
            r_term <= term_next;
        end
        if (i_ctl.win_push) begin
            r_win <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/here_string_delimiter_scanner.sv =====
// Here-string delimiter scanner top level: sequencer and result register.
// Depends on hsds_pkg, hsds_if, hsds_match and the assertion macro header.
//
//   channel   dir  handshake      payload
//   i_item    in   valid / ready  start_req, char_code[20:0], end_of_input
//   o_result  out  valid / ready  status[2:0], consumed_count[15:0]
//
// One word in, one word out. A word is taken every cycle while i_item.ready
// is high; its result lands in the output register at the edge that takes it.
// The terminator compare runs combinationally across all MAX_TERM lanes.
// i_item.ready is high when the output register is empty or being drained,
// so a stall on o_result backs up into the input after one held result.
// Synchronous reset returns the scanner to idle with an empty output.
`default_nettype none

`include "here_string_delimiter_scanner_macros.svh"

module here_string_delimiter_scanner import hsds_pkg::*; #(
    parameter int MAX_TERM = MAX_TERM_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hsds_in_if.sink       i_item,
    hsds_out_if.source    o_result
);

    // scan state
    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [COUNT_W-1:0] r_cnt, n_cnt;

    // output register
    logic               r_valid;
    t_status            r_status, n_status;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               in_acc;
    t_match_ctl         ctl;
    t_match_sts         sts;

    // working copies after a start word has reset the scan
    t_phase             eff_ph;
    logic [POS_W-1:0]   eff_pos;
    logic [COUNT_W-1:0] eff_cnt;
    logic               sp;

    assign i_item.ready = !r_valid || o_result.ready;
    assign in_acc       = i_item.valid && i_item.ready;
    assign sp           = is_space(i_item.char_code);

    hsds_match #(
        .MAX_TERM (MAX_TERM)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_item.char_code),
        .i_ctl   (ctl),
        .o_sts   (sts)
    );

    always_comb begin
        eff_ph  = i_item.start_req ? PH_LEAD : r_phase;
        eff_pos = i_item.start_req ? '0 : r_pos;
        eff_cnt = i_item.start_req ? '0 : r_cnt;

        n_phase  = eff_ph;
        n_pos    = eff_pos;
        n_cnt    = eff_cnt;
        n_status = ST_PENDING;
        n_count  = '0;
        ctl      = '0;
        ctl.term_clr = i_item.start_req;

        if (eff_ph == PH_IDLE) begin
            // nothing running: idle result, state untouched
            n_status = ST_IDLE;
        end else if (i_item.end_of_input) begin
            // end marker is not counted
            n_status = ST_EARLY;
            n_count  = eff_cnt;
        end else begin
            n_cnt   = (eff_cnt == COUNT_MAX) ? eff_cnt : eff_cnt + COUNT_W'(1);
            n_count = n_cnt;

            // first non-blank after leading whitespace starts the prefix
            if (eff_ph == PH_LEAD && !sp) begin
                n_phase = PH_PREFIX;
                n_pos   = '0;
            end

            case (n_phase)
                PH_LEAD: begin
                end
                PH_PREFIX: begin
                    if (i_item.char_code == prefix_char(n_pos)) begin
                        if (n_pos == POS_W'(PREFIX_LEN - 1)) begin
                            n_phase = PH_NEEDWS;
                        end
                        n_pos = n_pos + POS_W'(1);
                    end else begin
                        n_status = ST_MISMATCH;
                    end
                end
                PH_NEEDWS: begin
                    if (sp) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_status = ST_MISMATCH;
                    end
                end
                PH_GAP: begin
                    if (!sp) begin
                        ctl.term_push = 1'b1;
                        n_phase       = PH_TERM;
                    end
                end
                PH_TERM: begin
                    if (sp) begin
                        // the ending blank is the first body char
                        ctl.win_start = 1'b1;
                        ctl.win_push  = 1'b1;
                        n_phase       = PH_BODY;
                    end else if (sts.term_full) begin
                        n_status = ST_LONG;
                    end else begin
                        ctl.term_push = 1'b1;
                    end
                end
                PH_BODY: begin
                    ctl.win_push = 1'b1;
                    if (sts.hit) begin
                        n_status = ST_DONE;
                    end
                end
                default: begin
                    n_status = ST_MISMATCH;
                end
            endcase
        end

        // any final status ends the scan
        if (n_status != ST_PENDING) begin
            n_phase = PH_IDLE;
        end

        if (!in_acc) begin
            ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_cnt   <= n_cnt;
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.status         = r_status;
    assign o_result.consumed_count = r_count;

    // idle results never carry a count
    `HSDS_ASSERT_NOW(a_idle_count_zero,
        r_valid && r_status == ST_IDLE, r_count == '0)
    // a final status always leaves the scanner idle
    `HSDS_ASSERT_NEXT(a_final_goes_idle,
        in_acc && n_status != ST_PENDING, r_phase == PH_IDLE)
    // a completed token only comes out of the body phase
    `HSDS_ASSERT_NOW(a_done_from_body,
        in_acc && n_status == ST_DONE, r_phase == PH_BODY && !i_item.start_req)
    // pending scans never sit in the idle phase
    `HSDS_ASSERT_NEXT(a_pending_active,
        in_acc && n_status == ST_PENDING, r_phase != PH_IDLE)

endmodule

`default_nettype wire
